// ----- rtl/fcs_pkg.sv -----
// fcs_pkg: types, codes and constants shared by the fast charge sequencer.
// No dependencies; used by fcs_cfg, fcs_step and fast_charge_sequencer.
package fcs_pkg;

    // Phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_LINK  = 3'd1;
    localparam logic [2:0] PH_HAND  = 3'd2;
    localparam logic [2:0] PH_CFG   = 3'd3;
    localparam logic [2:0] PH_CFGOK = 3'd4;
    localparam logic [2:0] PH_CHG   = 3'd5;
    localparam logic [2:0] PH_STOP  = 3'd6;
    localparam logic [2:0] PH_FIN   = 3'd7;

    // Reported stage codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LINK = 3'd1;
    localparam logic [2:0] ST_HAND = 3'd2;
    localparam logic [2:0] ST_CFG  = 3'd3;
    localparam logic [2:0] ST_CHG  = 3'd4;
    localparam logic [2:0] ST_STO  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    // Work commands
    localparam logic [1:0] CMD_NONE      = 2'd0;
    localparam logic [1:0] CMD_NORSTOP   = 2'd1;
    localparam logic [1:0] CMD_NORSTART  = 2'd2;
    localparam logic [1:0] CMD_FORCESTOP = 2'd3;

    // Battery work states
    localparam logic [2:0] WS_OFF  = 3'd0;
    localparam logic [2:0] WS_IDLE = 3'd1;
    localparam logic [2:0] WS_RUN  = 3'd2;
    localparam logic [2:0] WS_ERR  = 3'd3;

    // Protection states
    localparam logic [1:0] PR_FULL = 2'd1;
    localparam logic [1:0] PR_SYS  = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_PLUG      = 3'd0;
    localparam logic [2:0] REG_UNPLUG    = 3'd1;
    localparam logic [2:0] REG_CC2_TOL   = 3'd2;
    localparam logic [2:0] REG_HS_TMO    = 3'd3;
    localparam logic [2:0] REG_READY_TMO = 3'd4;
    localparam logic [2:0] REG_STOP_TMO  = 3'd5;
    localparam logic [2:0] REG_SETTLE    = 3'd6;

    // Register reset values
    localparam logic [11:0] RST_PLUG      = 12'd900;
    localparam logic [11:0] RST_UNPLUG    = 12'd90;
    localparam logic [9:0]  RST_CC2_TOL   = 10'd100;
    localparam logic [7:0]  RST_HS_TMO    = 8'd120;
    localparam logic [7:0]  RST_READY_TMO = 8'd60;
    localparam logic [7:0]  RST_STOP_TMO  = 8'd10;
    localparam logic [7:0]  RST_SETTLE    = 8'd6;

    // CC2 nominal levels and retry spacing
    localparam logic [9:0] CC2_PLUGGED   = 10'd250;
    localparam logic [9:0] CC2_UNPLUGGED = 10'd500;
    localparam logic [7:0] RETRY_TICKS   = 8'd6;

    // Packed widths on the stream ports
    localparam int IN_BITS  = 40;
    localparam int OUT_BITS = 8;

    typedef struct packed {
        logic [11:0] plug_threshold;
        logic [11:0] unplug_threshold;
        logic [9:0]  cc2_tolerance;
        logic [7:0]  handshake_timeout;
        logic [7:0]  ready_timeout;
        logic [7:0]  stop_timeout;
        logic [7:0]  settle_ticks;
    } t_cfg;

    typedef struct packed {
        logic [11:0] supply_volt;
        logic [9:0]  cc2_volt;
        logic        chm_seen;
        logic        crm_confirmed;
        logic        brm_done;
        logic        cml_confirmed;
        logic        cro_confirmed;
        logic        charger_stop;
        logic [2:0]  work_state;
        logic [1:0]  protect_state;
        logic        current_idle;
        logic        contactors_off;
    } t_item;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] tick_timer;
        logic [2:0] stage_reg;
        logic       stop_flag;
    } t_state;

    typedef struct packed {
        logic [2:0] stage;
        logic       stop_request;
        logic [1:0] work_cmd;
        logic       clear_fault;
    } t_result;

    // |v - nominal| <= tol, all on 10 bits (difference never exceeds 1023)
    function automatic logic near_level(input logic [9:0] v, input logic [9:0] nominal,
                                        input logic [9:0] tol);
        logic [9:0] d;
        d = (v >= nominal) ? (v - nominal) : (nominal - v);
        return d <= tol;
    endfunction

    // t mod 6 for 8-bit t: quotient by reciprocal 171/1024, exact below 256
    function automatic logic [2:0] mod_retry(input logic [7:0] t);
        logic [15:0] prod;
        logic [5:0]  q;
        logic [8:0]  qm;
        logic [8:0]  r;
        prod = t * 8'd171;
        q    = prod[15:10];
        qm   = q * 3'd6;
        r    = {1'b0, t} - qm;
        return r[2:0];
    endfunction

endpackage

// ----- rtl/fast_charge_sequencer.sv -----
// fast_charge_sequencer: top level of the battery-side DC fast charge sequencer.
// Depends on fcs_pkg, fcs_cfg and fcs_step.
//
// Usage:
//   Each transfer on the s_axis channel is one 500 ms tick of measurements and
//   charger message flags; each tick yields exactly one transfer on m_axis with
//   the stage, stop request, work command and clear-fault pulse.
//   Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
//   while the block is idle; writes take effect on the next edge.
// Pipeline and throughput:
//   A tick lands in the input register and is evaluated by the single-pass
//   step logic into the result register once that register is free, which
//   raises m_axis_tvalid. One tick per cycle is sustained while m_axis_tready
//   is high, set by the single-pass state update loop.
// Reset:
//   Synchronous, active low. Phase returns to idle, timer, stage and stop
//   flag clear, registers take their default values, both channels empty.
// Stall:
//   While m_axis_tready is low the result register holds; one further tick
//   waits in the input register, then s_axis_tready drops.
module fast_charge_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_idx,
    input  logic [11:0]                     i_cfg_data,
    // tick input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [11:0] supply_volt, [21:12] cc2_volt, [22] chm_seen, [23] crm_confirmed,
    // [24] brm_done, [25] cml_confirmed, [26] cro_confirmed, [27] charger_stop,
    // [30:28] work_state, [32:31] protect_state, [33] current_idle,
    // [34] contactors_off, [39:35] zero
    input  logic [fcs_pkg::IN_BITS-1:0]     s_axis_tdata,
    // result output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] stage, [3] stop_request, [5:4] work_cmd, [6] clear_fault, [7] zero
    output logic [fcs_pkg::OUT_BITS-1:0]    m_axis_tdata
);

    fcs_pkg::t_cfg    cfg;
    fcs_pkg::t_item   r_item;
    fcs_pkg::t_item   n_item;
    fcs_pkg::t_state  r_state;
    fcs_pkg::t_state  n_state;
    fcs_pkg::t_result r_out;
    fcs_pkg::t_result n_out;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             out_free;
    logic             advance;
    logic             in_xfer;

    fcs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    fcs_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Handshake control
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Unpack input transfer
    always_comb begin
        n_item.supply_volt    = s_axis_tdata[11:0];
        n_item.cc2_volt       = s_axis_tdata[21:12];
        n_item.chm_seen       = s_axis_tdata[22];
        n_item.crm_confirmed  = s_axis_tdata[23];
        n_item.brm_done       = s_axis_tdata[24];
        n_item.cml_confirmed  = s_axis_tdata[25];
        n_item.cro_confirmed  = s_axis_tdata[26];
        n_item.charger_stop   = s_axis_tdata[27];
        n_item.work_state     = s_axis_tdata[30:28];
        n_item.protect_state  = s_axis_tdata[32:31];
        n_item.current_idle   = s_axis_tdata[33];
        n_item.contactors_off = s_axis_tdata[34];
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= n_item;
        end
    end

    // Sequencer state, updated once per evaluated tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= fcs_pkg::PH_IDLE;
            r_state.tick_timer <= '0;
            r_state.stage_reg  <= fcs_pkg::ST_IDLE;
            r_state.stop_flag  <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.clear_fault, r_out.work_cmd,
                            r_out.stop_request, r_out.stage};

endmodule

// ----- rtl/fcs_cfg.sv -----
// fcs_cfg: configuration register file of the fast charge sequencer.
// Depends on fcs_pkg for the register indexes, reset values and t_cfg.
module fcs_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [11:0]       i_cfg_data,
    output fcs_pkg::t_cfg     o_cfg
);

    fcs_pkg::t_cfg r_cfg;

    // Write decode; indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.plug_threshold    <= fcs_pkg::RST_PLUG;
            r_cfg.unplug_threshold  <= fcs_pkg::RST_UNPLUG;
            r_cfg.cc2_tolerance     <= fcs_pkg::RST_CC2_TOL;
            r_cfg.handshake_timeout <= fcs_pkg::RST_HS_TMO;
            r_cfg.ready_timeout     <= fcs_pkg::RST_READY_TMO;
            r_cfg.stop_timeout      <= fcs_pkg::RST_STOP_TMO;
            r_cfg.settle_ticks      <= fcs_pkg::RST_SETTLE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fcs_pkg::REG_PLUG:      r_cfg.plug_threshold    <= i_cfg_data;
                fcs_pkg::REG_UNPLUG:    r_cfg.unplug_threshold  <= i_cfg_data;
                fcs_pkg::REG_CC2_TOL:   r_cfg.cc2_tolerance     <= i_cfg_data[9:0];
                fcs_pkg::REG_HS_TMO:    r_cfg.handshake_timeout <= i_cfg_data[7:0];
                fcs_pkg::REG_READY_TMO: r_cfg.ready_timeout     <= i_cfg_data[7:0];
                fcs_pkg::REG_STOP_TMO:  r_cfg.stop_timeout      <= i_cfg_data[7:0];
                fcs_pkg::REG_SETTLE:    r_cfg.settle_ticks      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/fcs_step.sv -----
// fcs_step: per-tick next-state and result logic of the charge sequencer.
// Depends on fcs_pkg for codes, structs and the level/modulo helpers.
module fcs_step (
    input  fcs_pkg::t_cfg    i_cfg,
    input  fcs_pkg::t_state  i_state,
    input  fcs_pkg::t_item   i_item,
    output fcs_pkg::t_state  o_state,
    output fcs_pkg::t_result o_result
);

    fcs_pkg::t_state n_st;
    logic [1:0]      cmd;
    logic            clr;
    logic            near_plug;
    logic            near_unplug;
    logic            plugged;
    logic            unplugged;
    logic [2:0]      retry_phase;

    // Shared comparisons
    always_comb begin
        near_plug   = fcs_pkg::near_level(i_item.cc2_volt, fcs_pkg::CC2_PLUGGED,
                                          i_cfg.cc2_tolerance);
        near_unplug = fcs_pkg::near_level(i_item.cc2_volt, fcs_pkg::CC2_UNPLUGGED,
                                          i_cfg.cc2_tolerance);
        plugged     = i_item.supply_volt >= i_cfg.plug_threshold;
        unplugged   = i_item.supply_volt < i_cfg.unplug_threshold;
        retry_phase = fcs_pkg::mod_retry(i_state.tick_timer);
    end

    // Phase transitions
    always_comb begin
        n_st = i_state;
        cmd  = fcs_pkg::CMD_NONE;
        clr  = 1'b0;
        case (i_state.phase)
            fcs_pkg::PH_IDLE: begin
                if (plugged || i_item.chm_seen) begin
                    n_st.phase      = fcs_pkg::PH_LINK;
                    n_st.stage_reg  = fcs_pkg::ST_LINK;
                    n_st.tick_timer = '0;
                end else begin
                    n_st.stage_reg = fcs_pkg::ST_IDLE;
                end
                n_st.stop_flag = 1'b0;
            end
            fcs_pkg::PH_LINK: begin
                if (near_plug) begin
                    n_st.stop_flag = 1'b1;
                    case (i_item.work_state)
                        fcs_pkg::WS_ERR, fcs_pkg::WS_OFF: begin
                            // timer carried into finish
                            n_st.phase     = fcs_pkg::PH_FIN;
                            n_st.stage_reg = fcs_pkg::ST_FIN;
                        end
                        fcs_pkg::WS_IDLE: begin
                            n_st.phase      = fcs_pkg::PH_HAND;
                            n_st.stage_reg  = fcs_pkg::ST_HAND;
                            n_st.tick_timer = '0;
                        end
                        fcs_pkg::WS_RUN: begin
                            if (i_state.tick_timer >= i_cfg.stop_timeout) begin
                                n_st.phase      = fcs_pkg::PH_STOP;
                                n_st.stage_reg  = fcs_pkg::ST_STO;
                                n_st.tick_timer = '0;
                            end else begin
                                cmd             = fcs_pkg::CMD_NORSTOP;
                                n_st.tick_timer = i_state.tick_timer + 8'd1;
                            end
                        end
                        default: ; // other work states: keep waiting
                    endcase
                end else if (unplugged) begin
                    n_st.phase     = fcs_pkg::PH_IDLE;
                    n_st.stage_reg = fcs_pkg::ST_IDLE;
                end
            end
            fcs_pkg::PH_HAND: begin
                if (i_item.crm_confirmed && i_item.brm_done) begin
                    n_st.phase      = fcs_pkg::PH_CFG;
                    n_st.stage_reg  = fcs_pkg::ST_CFG;
                    n_st.tick_timer = '0;
                end else if (i_state.tick_timer >= i_cfg.handshake_timeout) begin
                    n_st.phase      = fcs_pkg::PH_FIN;
                    n_st.stage_reg  = fcs_pkg::ST_FIN;
                    n_st.tick_timer = '0;
                end else begin
                    n_st.tick_timer = i_state.tick_timer + 8'd1;
                end
            end
            fcs_pkg::PH_CFG: begin
                if (i_item.cml_confirmed) begin
                    n_st.stop_flag = 1'b0;
                    if (i_item.work_state == fcs_pkg::WS_OFF) begin
                        n_st.phase      = fcs_pkg::PH_FIN;
                        n_st.stage_reg  = fcs_pkg::ST_FIN;
                        n_st.tick_timer = '0;
                    end else if (i_item.work_state == fcs_pkg::WS_RUN) begin
                        // stage stays at config
                        n_st.phase      = fcs_pkg::PH_CFGOK;
                        n_st.tick_timer = '0;
                    end else if (i_state.tick_timer >= i_cfg.ready_timeout) begin
                        n_st.phase      = fcs_pkg::PH_FIN;
                        n_st.stage_reg  = fcs_pkg::ST_FIN;
                        n_st.tick_timer = '0;
                    end else begin
                        // start / clear / force-stop retries every six ticks
                        if (i_item.work_state == fcs_pkg::WS_IDLE) begin
                            if (i_item.protect_state == fcs_pkg::PR_SYS && retry_phase == 3'd0)
                                clr = 1'b1;
                            else if (retry_phase == 3'd1)
                                cmd = fcs_pkg::CMD_NORSTART;
                        end else if (i_item.work_state == fcs_pkg::WS_ERR
                                     && retry_phase == 3'd0) begin
                            cmd = fcs_pkg::CMD_FORCESTOP;
                            clr = 1'b1;
                        end
                        n_st.tick_timer = i_state.tick_timer + 8'd1;
                    end
                end else if (i_state.tick_timer >= i_cfg.handshake_timeout) begin
                    n_st.phase      = fcs_pkg::PH_FIN;
                    n_st.stage_reg  = fcs_pkg::ST_FIN;
                    n_st.tick_timer = '0;
                end else begin
                    n_st.tick_timer = i_state.tick_timer + 8'd1;
                end
            end
            fcs_pkg::PH_CFGOK: begin
                if (i_item.cro_confirmed) begin
                    n_st.phase      = fcs_pkg::PH_CHG;
                    n_st.stage_reg  = fcs_pkg::ST_CHG;
                    n_st.tick_timer = '0;
                end else if (i_state.tick_timer >= i_cfg.handshake_timeout) begin
                    n_st.phase      = fcs_pkg::PH_STOP;
                    n_st.stage_reg  = fcs_pkg::ST_STO;
                    n_st.tick_timer = '0;
                end else begin
                    n_st.tick_timer = i_state.tick_timer + 8'd1;
                end
            end
            fcs_pkg::PH_CHG: begin
                if (i_item.protect_state == fcs_pkg::PR_FULL
                    || i_item.protect_state == fcs_pkg::PR_SYS
                    || i_item.charger_stop || near_unplug) begin
                    n_st.phase      = fcs_pkg::PH_STOP;
                    n_st.stage_reg  = fcs_pkg::ST_STO;
                    n_st.tick_timer = '0;
                end
            end
            fcs_pkg::PH_STOP: begin
                n_st.stop_flag = 1'b1;
                if (i_item.current_idle) begin
                    if (i_state.tick_timer >= i_cfg.settle_ticks) begin
                        n_st.phase      = fcs_pkg::PH_FIN;
                        n_st.stage_reg  = fcs_pkg::ST_FIN;
                        n_st.tick_timer = '0;
                    end else begin
                        n_st.tick_timer = i_state.tick_timer + 8'd1;
                    end
                end
            end
            default: begin
                // finished: hold the stop request until unplugged
                n_st.stop_flag = 1'b1;
                if (i_item.current_idle) begin
                    if (!i_item.contactors_off)
                        cmd = fcs_pkg::CMD_NORSTOP;
                    if (unplugged && near_unplug) begin
                        n_st.phase     = fcs_pkg::PH_IDLE;
                        n_st.stage_reg = fcs_pkg::ST_IDLE;
                    end
                end else if (i_state.tick_timer >= i_cfg.stop_timeout) begin
                    cmd = fcs_pkg::CMD_FORCESTOP;
                end else begin
                    n_st.tick_timer = i_state.tick_timer + 8'd1;
                end
            end
        endcase
    end

    assign o_state               = n_st;
    assign o_result.stage        = n_st.stage_reg;
    assign o_result.stop_request = n_st.stop_flag;
    assign o_result.work_cmd     = cmd;
    assign o_result.clear_fault  = clr;

endmodule
